// ===== src/msadpcm_pkg.sv =====
// Shared types, constants and the step adaptation table for the
// MS ADPCM block decoder. No dependencies.
package msadpcm_pkg;

    // Coefficient pair indices at or above this count are clamped to the last pair
    localparam int NUM_COEF_PAIRS = 7;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPB        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D     = 3'd5;

    localparam logic [3:0] HDR_LEN_MONO   = 4'd7;
    localparam logic [3:0] HDR_LEN_STEREO = 4'd14;

    // Header field numbers after the predictor bytes
    localparam logic [1:0] FIELD_DELTA   = 2'd0;
    localparam logic [1:0] FIELD_SAMPLE1 = 2'd1;

    localparam logic [15:0] DELTA_RESET = 16'd16;
    localparam logic [15:0] SPB_RESET   = 16'd2;
    localparam logic [15:0] SD_AFTER_HDR = 16'd2;

    localparam logic signed [18:0] DELTA_MIN = 19'sd16;
    localparam logic signed [18:0] DELTA_MAX = 19'sd32767;
    localparam logic signed [25:0] SAMPLE_MAX = 26'sd32767;
    localparam logic signed [25:0] SAMPLE_MIN = -26'sd32768;

    typedef struct packed {
        logic [15:0] prev;
        logic [15:0] older;
        logic [15:0] delta;
    } chan_state_t;

    function automatic logic [9:0] adapt_factor(input logic [3:0] code);
        logic [9:0] f;
        case (code)
            4'd4, 4'd12:  f = 10'd307;
            4'd5, 4'd11:  f = 10'd409;
            4'd6, 4'd10:  f = 10'd512;
            4'd7, 4'd9:   f = 10'd614;
            4'd8:         f = 10'd768;
            default:      f = 10'd230;
        endcase
        return f;
    endfunction

endpackage

// ===== src/ms_adpcm_block_decoder.sv =====
// MS ADPCM block decoder top level: header parser, nibble sequencer, output register.
// Depends on msadpcm_pkg and msadpcm_nibble_dec.
//
//   port group   dir  handshake            payload
//   in           in   in_valid/in_stall    data_byte, block_start
//   out          out  out_valid/out_stall  sample, channel, last_of_item
//   cfg          in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A header byte completing a channel's sample2 emits sample2 and then sample1.
// A data byte is decoded one nibble per cycle while the output has room, high
// nibble first, through the single nibble decoder, state updated in place; in
// mono the low nibble is skipped when only one sample is still due. A byte with
// no result retires without waiting for output room. Async active-low reset puts
// the block in its idle, decoded-nothing state; cfg_ready is always high.
// out_stall holds the sequencer only on cycles that produce a sample.
module ms_adpcm_block_decoder
#(
    parameter int NUM_COEF_PAIRS = msadpcm_pkg::NUM_COEF_PAIRS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  block_start,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [15:0]    sample,
    output logic                  channel,
    output logic                  last_of_item,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [msadpcm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]           cfg_data
);

    // configuration
    logic        stereo_reg;
    logic [15:0] spb_reg;
    logic [63:0] coef_reg [4];

    // decoder state
    logic [3:0]               hdr_pos_reg,   hdr_pos_next;
    logic [7:0]               low_hold_reg,  low_hold_next;
    logic [2:0]               coef_idx_reg  [2];
    logic [2:0]               coef_idx_next [2];
    msadpcm_pkg::chan_state_t chan_reg      [2];
    msadpcm_pkg::chan_state_t chan_next     [2];
    logic [15:0]              sd_reg,        sd_next;

    // work stage
    logic       work_valid_reg, work_valid_next;
    logic [7:0] work_byte_reg;
    logic       work_start_reg;
    logic       phase_reg,     phase_next;
    logic       pend_hdr_reg,  pend_hdr_next;
    logic       pend_ch_reg,   pend_ch_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] sample_reg;
    logic        channel_reg;
    logic        last_reg;

    logic        accept;
    logic        done;
    logic        emit;
    logic [15:0] emit_sample;
    logic        emit_ch;
    logic        emit_last;
    logic        out_free;

    logic        dec_ch;
    logic [3:0]  dec_code;
    logic [2:0]  dec_idx;
    logic [63:0] dec_coef_word;
    logic [31:0] dec_pair;
    logic [15:0] dec_sample;
    logic [15:0] dec_delta;

    logic [3:0]  hp;
    logic [3:0]  hdr_len;
    logic [3:0]  nch;
    logic [3:0]  q;
    logic [1:0]  field;
    logic        hch;
    logic [15:0] hval;
    logic [7:0]  coef_clamped;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg  <= 1'b0;
            spb_reg     <= msadpcm_pkg::SPB_RESET;
            coef_reg[0] <= '0;
            coef_reg[1] <= '0;
            coef_reg[2] <= '0;
            coef_reg[3] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                msadpcm_pkg::CFG_STEREO: stereo_reg  <= cfg_data[0];
                msadpcm_pkg::CFG_SPB:    spb_reg     <= cfg_data[15:0];
                msadpcm_pkg::CFG_COEF_A: coef_reg[0] <= cfg_data;
                msadpcm_pkg::CFG_COEF_B: coef_reg[1] <= cfg_data;
                msadpcm_pkg::CFG_COEF_C: coef_reg[2] <= cfg_data;
                msadpcm_pkg::CFG_COEF_D: coef_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // nibble decoder: high nibble of channel 0 first, then low nibble
    assign dec_ch        = phase_reg ? pend_ch_reg : 1'b0;
    assign dec_code      = phase_reg ? work_byte_reg[3:0] : work_byte_reg[7:4];
    assign dec_idx       = coef_idx_reg[dec_ch];
    assign dec_coef_word = coef_reg[dec_idx[2:1]];
    assign dec_pair      = dec_idx[0] ? dec_coef_word[63:32] : dec_coef_word[31:0];

    msadpcm_nibble_dec u_nibble_dec
    (
        .code       (dec_code),
        .st         (chan_reg[dec_ch]),
        .coef1      (dec_pair[15:0]),
        .coef2      (dec_pair[31:16]),
        .new_sample (dec_sample),
        .new_delta  (dec_delta)
    );

    // header decode of the current byte
    assign hp       = work_start_reg ? 4'd0 : hdr_pos_reg;
    assign hdr_len  = stereo_reg ? msadpcm_pkg::HDR_LEN_STEREO : msadpcm_pkg::HDR_LEN_MONO;
    assign nch      = stereo_reg ? 4'd2 : 4'd1;
    assign q        = hp - nch;
    assign field    = stereo_reg ? q[3:2] : q[2:1];
    assign hch      = stereo_reg ? q[1] : 1'b0;
    assign hval     = {work_byte_reg, low_hold_reg};
    assign coef_clamped = (work_byte_reg > 8'(NUM_COEF_PAIRS - 1))
                        ? 8'(NUM_COEF_PAIRS - 1) : work_byte_reg;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        hdr_pos_next     = hdr_pos_reg;
        low_hold_next    = low_hold_reg;
        coef_idx_next[0] = coef_idx_reg[0];
        coef_idx_next[1] = coef_idx_reg[1];
        chan_next[0]     = chan_reg[0];
        chan_next[1]     = chan_reg[1];
        sd_next          = sd_reg;
        phase_next       = phase_reg;
        pend_hdr_next    = pend_hdr_reg;
        pend_ch_next     = pend_ch_reg;
        done             = 1'b0;
        emit             = 1'b0;
        emit_sample      = dec_sample;
        emit_ch          = dec_ch;
        emit_last        = 1'b1;

        if (work_valid_reg)
        begin
            if (!phase_reg)
            begin
                if (hp < hdr_len)
                begin
                    // sample2 completion yields two beats, so it waits for room
                    if (hp >= nch && q[0] && field > msadpcm_pkg::FIELD_SAMPLE1)
                    begin
                        if (out_free)
                        begin
                            chan_next[hch].older = hval;
                            emit          = 1'b1;
                            emit_sample   = hval;
                            emit_ch       = hch;
                            emit_last     = 1'b0;
                            phase_next    = 1'b1;
                            pend_hdr_next = 1'b1;
                            pend_ch_next  = hch;
                        end
                    end
                    else
                    begin
                        done = 1'b1;
                        if (hp < nch)
                            coef_idx_next[hp[0]] = coef_clamped[2:0];
                        else if (!q[0])
                            low_hold_next = work_byte_reg;
                        else if (field == msadpcm_pkg::FIELD_DELTA)
                            chan_next[hch].delta = hval;
                        else
                            chan_next[hch].prev = hval;
                    end

                    if (done || (out_free && !done))
                    begin
                        hdr_pos_next = hp + 4'd1;
                        if (hp + 4'd1 == hdr_len)
                            sd_next = msadpcm_pkg::SD_AFTER_HDR;
                    end
                end
                else if (sd_reg < spb_reg)
                begin
                    if (out_free)
                    begin
                        chan_next[0].older = chan_reg[0].prev;
                        chan_next[0].prev  = dec_sample;
                        chan_next[0].delta = dec_delta;
                        sd_next            = sd_reg + 16'd1;
                        emit               = 1'b1;
                        pend_hdr_next      = 1'b0;
                        pend_ch_next       = stereo_reg;
                        if (stereo_reg || (17'(sd_reg) + 17'd1 < 17'(spb_reg)))
                        begin
                            emit_last  = 1'b0;
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                end
                else
                begin
                    // block already full: byte yields nothing
                    done = 1'b1;
                end
            end
            else if (out_free)
            begin
                emit       = 1'b1;
                done       = 1'b1;
                phase_next = 1'b0;
                if (pend_hdr_reg)
                begin
                    emit_sample = chan_reg[pend_ch_reg].prev;
                    emit_ch     = pend_ch_reg;
                end
                else
                begin
                    chan_next[pend_ch_reg].older = chan_reg[pend_ch_reg].prev;
                    chan_next[pend_ch_reg].prev  = dec_sample;
                    chan_next[pend_ch_reg].delta = dec_delta;
                    if (!pend_ch_reg)
                        sd_next = sd_reg + 16'd1;
                end
            end
        end
    end

    assign in_stall = work_valid_reg && !done;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            work_valid_next = 1'b1;
        else if (done)
            work_valid_next = 1'b0;
        else
            work_valid_next = work_valid_reg;

        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg     <= '0;
            low_hold_reg    <= '0;
            coef_idx_reg[0] <= '0;
            coef_idx_reg[1] <= '0;
            chan_reg[0]     <= '{prev: 16'd0, older: 16'd0, delta: msadpcm_pkg::DELTA_RESET};
            chan_reg[1]     <= '{prev: 16'd0, older: 16'd0, delta: msadpcm_pkg::DELTA_RESET};
            sd_reg          <= '0;
            work_valid_reg  <= 1'b0;
            phase_reg       <= 1'b0;
            pend_hdr_reg    <= 1'b0;
            pend_ch_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            hdr_pos_reg     <= hdr_pos_next;
            low_hold_reg    <= low_hold_next;
            coef_idx_reg[0] <= coef_idx_next[0];
            coef_idx_reg[1] <= coef_idx_next[1];
            chan_reg[0]     <= chan_next[0];
            chan_reg[1]     <= chan_next[1];
            sd_reg          <= sd_next;
            work_valid_reg  <= work_valid_next;
            phase_reg       <= phase_next;
            pend_hdr_reg    <= pend_hdr_next;
            pend_ch_reg     <= pend_ch_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_byte_reg  <= data_byte;
            work_start_reg <= block_start;
        end
        if (emit)
        begin
            sample_reg  <= emit_sample;
            channel_reg <= emit_ch;
            last_reg    <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign channel      = channel_reg;
    assign last_of_item = last_reg;

endmodule

// ===== src/msadpcm_nibble_dec.sv =====
// Decodes one 4-bit ADPCM code: prediction, step add with clamp, delta adapt.
// Purely combinational. Depends on msadpcm_pkg.
module msadpcm_nibble_dec
(
    input  logic [3:0]                code,
    input  msadpcm_pkg::chan_state_t  st,
    input  logic signed [15:0]        coef1,
    input  logic signed [15:0]        coef2,
    output logic [15:0]               new_sample,
    output logic [15:0]               new_delta
);

    logic signed [15:0] s1;
    logic signed [15:0] s2;
    logic signed [15:0] d;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [32:0] psum;
    logic signed [32:0] psum_adj;
    logic signed [24:0] pred;
    logic signed [4:0]  nib;
    logic signed [20:0] dstep;
    logic signed [25:0] nv;
    logic signed [10:0] factor;
    logic signed [26:0] dprod;
    logic signed [18:0] dscaled;

    assign s1  = st.prev;
    assign s2  = st.older;
    assign d   = st.delta;
    assign nib = {code[3], code};

    assign p1   = s1 * coef1;
    assign p2   = s2 * coef2;
    assign psum = 33'(p1) + 33'(p2);
    // divide by 256 rounding toward zero
    assign psum_adj = psum[32] ? psum + 33'sd255 : psum;
    assign pred     = 25'(psum_adj >>> 8);

    assign dstep = d * nib;
    assign nv    = 26'(pred) + 26'(dstep);

    always_comb
    begin
        if (nv > msadpcm_pkg::SAMPLE_MAX)
            new_sample = 16'h7fff;
        else if (nv < msadpcm_pkg::SAMPLE_MIN)
            new_sample = 16'h8000;
        else
            new_sample = nv[15:0];
    end

    // negative products land below the floor either way, so a plain shift does
    assign factor  = $signed({1'b0, msadpcm_pkg::adapt_factor(code)});
    assign dprod   = d * factor;
    assign dscaled = 19'(dprod >>> 8);

    always_comb
    begin
        if (dscaled < msadpcm_pkg::DELTA_MIN)
            new_delta = 16'd16;
        else if (dscaled > msadpcm_pkg::DELTA_MAX)
            new_delta = 16'd32767;
        else
            new_delta = dscaled[15:0];
    end

endmodule

// ===== test/tb_ms_adpcm_block_decoder.sv =====
// Self-checking testbench for ms_adpcm_block_decoder: feeds MS ADPCM blocks byte by
// byte with random gaps and output stalls, predicts every PCM beat and compares them.
// Depends on msadpcm_pkg and the decoder RTL.
module tb_ms_adpcm_block_decoder;

    typedef struct packed {
        logic [15:0] smp;
        logic        ch;
        logic        last;
    } pcm_beat_t;

    typedef struct packed {
        logic [7:0] b;
        logic       start;
        logic       hold;   // sender waits for all samples before this beat
    } byte_beat_t;

    localparam int STEP_SCALE [16] = '{230, 230, 230, 230, 307, 409, 512, 614,
                                       768, 614, 512, 409, 307, 230, 230, 230};

    // Common MS ADPCM predictor pairs; pair 7 is set to the extremes
    localparam logic [63:0] STD_COEF_A = {16'hFF00, 16'h0200, 16'h0000, 16'h0100};
    localparam logic [63:0] STD_COEF_B = {16'h0040, 16'h00C0, 16'h0000, 16'h0000};
    localparam logic [63:0] STD_COEF_C = {16'hFF30, 16'h01CC, 16'h0000, 16'h00F0};
    localparam logic [63:0] STD_COEF_D = {16'h8000, 16'h7FFF, 16'hFF18, 16'h0188};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte = 8'd0;
    logic                 block_start = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [15:0]   sample;
    logic                 channel;
    logic                 last_of_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [msadpcm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = 64'd0;

    // decoder image: configuration
    logic        cfg_st;
    logic [15:0] cfg_spb;
    logic [63:0] coef_reg [4];
    // decoder image: state
    logic [3:0]  hdr_pos;
    logic [7:0]  byte_lo;
    logic [2:0]  pair_sel [2];
    logic [15:0] step [2];
    logic [15:0] hist1 [2];
    logic [15:0] hist2 [2];
    logic [16:0] n_done;

    pcm_beat_t   pcm_expected [$];
    byte_beat_t  byte_q [$];
    byte_beat_t  nxt;
    pcm_beat_t   want;
    int          bytes_in_flight = 0;
    int          err_cnt = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          beats_seen = 0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;

    ms_adpcm_block_decoder DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .block_start  (block_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample),
        .channel      (channel),
        .last_of_item (last_of_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void reset_image();
        cfg_st = 1'b0;
        cfg_spb = 16'd2;
        hdr_pos = '0;
        byte_lo = '0;
        n_done = '0;
        for (int i = 0; i < 4; i++)
            coef_reg[i] = 64'd0;
        for (int c = 0; c < 2; c++)
        begin
            pair_sel[c] = '0;
            step[c] = 16'd16;
            hist1[c] = '0;
            hist2[c] = '0;
        end
    endfunction

    function automatic logic [15:0] decode_nibble(int ch, logic [3:0] code);
        logic [31:0] pair;
        longint c1, c2, s1, s2, d, nib, pred, nv, nd;
        pair = pair_sel[ch][0] ? coef_reg[pair_sel[ch][2:1]][63:32]
                               : coef_reg[pair_sel[ch][2:1]][31:0];
        c1 = $signed(pair[15:0]);
        c2 = $signed(pair[31:16]);
        s1 = $signed(hist1[ch]);
        s2 = $signed(hist2[ch]);
        d = $signed(step[ch]);
        nib = $signed(code);
        pred = (s1 * c1 + s2 * c2) / 256;
        nv = pred + d * nib;
        if (nv > 32767)
            nv = 32767;
        else if (nv < -32768)
            nv = -32768;
        nd = d * STEP_SCALE[code] / 256;
        if (nd < 16)
            nd = 16;
        if (nd > 32767)
            nd = 32767;
        step[ch] = nd[15:0];
        hist2[ch] = hist1[ch];
        hist1[ch] = nv[15:0];
        return nv[15:0];
    endfunction

    // Advance the image by one accepted byte and queue the samples it yields
    function automatic void absorb_byte(logic [7:0] b, logic st);
        pcm_beat_t   got [2];
        int          nch, hlen, p, q, fld, ch, n;
        logic [15:0] v;
        nch = cfg_st ? 2 : 1;
        hlen = 7 * nch;
        n = 0;
        if (st)
            hdr_pos = '0;
        if (hdr_pos < hlen)
        begin
            p = hdr_pos;
            if (p < nch)
                pair_sel[p % 2] = (b > msadpcm_pkg::NUM_COEF_PAIRS - 1)
                                ? 3'(msadpcm_pkg::NUM_COEF_PAIRS - 1) : b[2:0];
            else
            begin
                q = p - nch;
                fld = q / (2 * nch);
                ch = (q / 2) % nch;
                if (q % 2 == 0)
                    byte_lo = b;
                else
                begin
                    v = {b, byte_lo};
                    if (fld == 0)
                        step[ch] = v;
                    else if (fld == 1)
                        hist1[ch] = v;
                    else
                    begin
                        // sample2 goes out first, then sample1
                        hist2[ch] = v;
                        got[0] = '{hist2[ch], ch[0], 1'b0};
                        got[1] = '{hist1[ch], ch[0], 1'b0};
                        n = 2;
                    end
                end
            end
            hdr_pos = 4'(p + 1);
            if (hdr_pos == hlen)
                n_done = 17'd2;
        end
        else if (nch == 2)
        begin
            if (n_done < cfg_spb)
            begin
                got[0] = '{decode_nibble(0, b[7:4]), 1'b0, 1'b0};
                got[1] = '{decode_nibble(1, b[3:0]), 1'b1, 1'b0};
                n = 2;
                n_done++;
            end
        end
        else
        begin
            if (n_done < cfg_spb)
            begin
                got[n] = '{decode_nibble(0, b[7:4]), 1'b0, 1'b0};
                n++;
                n_done++;
            end
            // low nibble is dropped when only one sample was still due
            if (n_done < cfg_spb)
            begin
                got[n] = '{decode_nibble(0, b[3:0]), 1'b0, 1'b0};
                n++;
                n_done++;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            got[i].last = (i == n - 1);
            pcm_expected.push_back(got[i]);
        end
    endfunction

    function automatic void push_item(logic [7:0] b, logic st, logic hold);
        byte_q.push_back('{b, st, hold});
        bytes_in_flight++;
    endfunction

    // One block with random content: mostly well formed, sometimes with noise
    // in front, a cut header or a short data part. Returns the bytes that count.
    function automatic int push_block(bit hold_first);
        logic [7:0]  hdr [14];
        logic [15:0] v;
        int          nch, hlen, k, cut, need, nd, counted;
        nch = cfg_st ? 2 : 1;
        hlen = 7 * nch;
        k = 0;
        counted = 0;
        for (int c = 0; c < nch; c++)
        begin
            hdr[k] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
            k++;
        end
        for (int f = 0; f < 3; f++)
        begin
            for (int c = 0; c < nch; c++)
            begin
                if (f == 0)
                    case ($urandom_range(0, 9))
                        0:       v = 16'($urandom);
                        1:       v = 16'($urandom_range(0, 15));
                        default: v = 16'($urandom_range(16, 1500));
                    endcase
                else if ($urandom_range(0, 7) == 0)
                    v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                else
                    v = 16'($urandom);
                hdr[k] = v[7:0];
                hdr[k + 1] = v[15:8];
                k += 2;
            end
        end
        if ($urandom_range(0, 9) == 0)
        begin
            nd = $urandom_range(1, 3);
            for (int i = 0; i < nd; i++)
                push_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
            counted += nd;
        end
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, hlen - 1) : hlen;
        for (int i = 0; i < cut; i++)
            push_item(hdr[i], i == 0, hold_first && i == 0);
        counted += cut;
        if (cut == hlen)
        begin
            need = cfg_st ? cfg_spb - 2 : (cfg_spb - 1) / 2;
            if (need > 48)
                need = 48;
            nd = ($urandom_range(0, 5) == 0) ? $urandom_range(0, need) : need;
            for (int i = 0; i < nd; i++)
                push_item(($urandom_range(0, 15) == 0) ? {2{4'h7 + 4'($urandom_range(0, 1))}}
                                                       : 8'($urandom), 1'b0, 1'b0);
            counted += nd;
            // bytes past a full block only get swallowed
            if (nd == need && need < 48 && $urandom_range(0, 3) == 0)
                for (int i = 0; i < $urandom_range(1, 2); i++)
                    push_item(8'($urandom), 1'b0, 1'b0);
        end
        return counted;
    endfunction

    function automatic void fill_random();
        int n, blk;
        n = 0;
        blk = 0;
        while (n < 250)
        begin
            n += push_block(blk == 3 || $urandom_range(0, 39) == 0);
            blk++;
        end
    endfunction

    task automatic cfg_write(input logic [msadpcm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            msadpcm_pkg::CFG_STEREO: cfg_st = val[0];
            msadpcm_pkg::CFG_SPB:    cfg_spb = val[15:0];
            default:                 coef_reg[2'(idx - msadpcm_pkg::CFG_COEF_A)] = val;
        endcase
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (bytes_in_flight != 0 || pcm_expected.size() != 0);
        // header bytes without samples may still be retiring
        repeat (4) @(posedge clk);
    endtask

    task automatic reconfigure(input logic st, input logic [15:0] spb,
                               input logic [63:0] ca, cb, cc, cd);
        settle();
        cfg_write(msadpcm_pkg::CFG_STEREO, {63'd0, st});
        cfg_write(msadpcm_pkg::CFG_SPB, {48'd0, spb});
        cfg_write(msadpcm_pkg::CFG_COEF_A, ca);
        cfg_write(msadpcm_pkg::CFG_COEF_B, cb);
        cfg_write(msadpcm_pkg::CFG_COEF_C, cc);
        cfg_write(msadpcm_pkg::CFG_COEF_D, cd);
        cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string fld, input int exp_v, input int act_v);
        if (err_cnt < 40)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, fld, exp_v, act_v);
        err_cnt++;
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'd0;
            block_start <= 1'b0;
            gap_left = 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                absorb_byte(data_byte, block_start);
                bytes_in_flight--;
                if (block_start)
                    in_calm = ($urandom_range(0, 4) == 0);
                gap_left = in_calm ? 0 : $urandom_range(0, 8);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (byte_q.size() != 0 && !(byte_q[0].hold && pcm_expected.size() != 0))
            begin
                nxt = byte_q.pop_front();
                data_byte <= nxt.b;
                block_start <= nxt.start;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // sample monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pcm_expected.size() == 0)
                begin
                    if (err_cnt < 40)
                        $display("%0t: unexpected sample beat: expected none, got %0d ch %0d",
                                 $time, sample, channel);
                    err_cnt++;
                end
                else
                begin
                    want = pcm_expected.pop_front();
                    if (sample !== want.smp)
                        note_mismatch("sample", $signed(want.smp), sample);
                    if (channel !== want.ch)
                        note_mismatch("channel", want.ch, channel);
                    if (last_of_item !== want.last)
                        note_mismatch("last_of_item", want.last, last_of_item);
                end
                beats_seen++;
                if (beats_seen % 32 == 0)
                    out_calm = ($urandom_range(0, 4) == 0);
                stall_left = out_calm ? 0 : $urandom_range(0, 8);
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left > 0);
        end
    end

    initial
    begin
        reset_image();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        reconfigure(1'b0, 16'd5, STD_COEF_A, STD_COEF_B, STD_COEF_C, STD_COEF_D);
        // no block start yet, big predictor index, negative delta, extreme samples,
        // then an odd count drops a low nibble and a full block swallows a byte
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h80, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h7F, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h80, 1'b0, 1'b0);
        push_item(8'h7F, 1'b0, 1'b0);
        push_item(8'h80, 1'b0, 1'b0);
        push_item(8'h08, 1'b0, 1'b0);
        // delta below the minimum
        push_item(8'h01, 1'b1, 1'b0);
        push_item(8'h03, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h01, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h88, 1'b0, 1'b0);
        // header left half done, then the mode flips to stereo under it
        push_item(8'h07, 1'b1, 1'b0);
        push_item(8'h10, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);

        reconfigure(1'b1, 16'd2, 64'd0, 64'd0, 64'd0, 64'd0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h20, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h7F, 1'b0, 1'b0);
        fill_random();

        reconfigure(1'b0, 16'hFFFF, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        fill_random();

        reconfigure(1'b1, 16'($urandom_range(3, 60)),
                    64'h8000_7FFF_7FFF_8000, 64'h7FFF_7FFF_8000_8000,
                    64'h7FFF_8000_8000_7FFF, 64'h8000_8000_7FFF_7FFF);
        fill_random();

        reconfigure(1'b0, 16'($urandom_range(3, 60)), '1, '1, '1, '1);
        fill_random();

        reconfigure(1'b1, 16'hFFFF, STD_COEF_A, STD_COEF_B, STD_COEF_C, STD_COEF_D);
        fill_random();

        reconfigure(1'b0, 16'd2, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        fill_random();

        do
            @(posedge clk);
        while (bytes_in_flight != 0 || pcm_expected.size() != 0);
        repeat (20) @(posedge clk);
        if (pcm_expected.size() != 0)
        begin
            $display("%0t: %0d expected samples never arrived", $time, pcm_expected.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("%0t: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
